### rtl/sitda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned DECADES   = 10;           // 10^9 .. 10^0
    localparam int unsigned DECADE_W  = 4;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned SCALED_W  = 34;           // holds 9 * 10^9
    localparam int unsigned DIFF_W    = SCALED_W + 1; // sign bit on top

    localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 8'd48; // '0'
    localparam logic [CHAR_W-1:0]   CHAR_MINUS = 8'd45; // '-'
    localparam logic [DECADE_W-1:0] TOP_DECADE = DECADE_W'(DECADES - 1);

    typedef logic [SCALED_W-1:0] scaled_row_t [DECADES];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;   // capture magnitude and sign
        logic sign;   // sign slot: emits '-' for negative values
        logic step;   // resolve one decimal digit
    } cmd_t;

    typedef struct packed {
        logic out_stall;    // output register full and not taken
        logic last_decade;  // working on the units digit
    } status_t;

    // d * 10^k for every decade k, evaluated at elaboration only
    function automatic scaled_row_t scaled_row(input int unsigned d);
        scaled_row_t  row;
        longint unsigned p;
        p = 64'd1;
        for (int unsigned k = 0; k < DECADES; k++) begin
            row[k] = SCALED_W'(p * d);
            p      = p * 64'd10;
        end
        return row;
    endfunction

endpackage
`default_nettype wire

### rtl/signed_int_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, MSD first.
//
//   Channel | Dir | Ports                      | Payload
//   --------+-----+----------------------------+------------------------------
//   s_      | in  | s_tvalid s_tready s_tdata  | value (32b signed)
//   m_      | out | m_tvalid m_tready m_tdata  | char_code (8b), is_last=tlast
//
// Each number passes through one load step, one sign slot and ten decade
// steps (10^9 down to 10^0), one digit resolved per decade by a bank
// of nine trial subtractors. Leading-zero decades produce no transaction.
// A full output register that is not taken holds the sequencer in place.
// aresetn is synchronous, active low; it clears the sequencer and out valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] char_code
    output logic             m_tlast    // is_last
);

    // controller to datapath commands, datapath back to controller status
    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t status;

    // sequencer: accepts a transaction only while idle
    sitda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // magnitude, digit extraction and the output register
    sitda_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

### rtl/sitda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: load, sign slot, then one decade per cycle from 10^9 down while the output is not stalled.
// ----------------------------------------------------------------------------
module sitda_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire sitda_pkg::status_t status,
    output sitda_pkg::cmd_t         cmd
);

    sitda_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sitda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sitda_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sitda_pkg::ST_SIGN;
                end
            end
            sitda_pkg::ST_SIGN: begin
                if (!status.out_stall) begin
                    state_next = sitda_pkg::ST_DIGIT;
                end
            end
            sitda_pkg::ST_DIGIT: begin
                if (!status.out_stall && status.last_decade) begin
                    state_next = sitda_pkg::ST_IDLE;
                end
            end
            default: state_next = sitda_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            sitda_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sitda_pkg::ST_SIGN: begin
                cmd.sign = !status.out_stall;
            end
            sitda_pkg::ST_DIGIT: begin
                cmd.step = !status.out_stall;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/sitda_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude register, parallel d*10^k trial subtract, output register.
// ----------------------------------------------------------------------------
module sitda_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [sitda_pkg::VALUE_W-1:0]         s_tdata,
    input  wire sitda_pkg::cmd_t                       cmd,
    output sitda_pkg::status_t                         status,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [sitda_pkg::CHAR_W-1:0]               m_tdata,
    output logic                                       m_tlast
);

    logic [sitda_pkg::VALUE_W-1:0]  mag_reg,     mag_next;
    logic                           neg_reg,     neg_next;
    logic [sitda_pkg::DECADE_W-1:0] decade_reg,  decade_next;
    logic                           started_reg, started_next;
    logic                           valid_reg,   valid_next;
    logic [sitda_pkg::CHAR_W-1:0]   char_reg,    char_next;
    logic                           last_reg,    last_next;

    logic [sitda_pkg::DIFF_W-1:0]   diff [1:9];
    logic [sitda_pkg::DIGIT_W-1:0]  digit;
    logic [sitda_pkg::VALUE_W-1:0]  remainder;
    logic                           emit_digit;

    // trial subtraction of every multiple of the current decade
    for (genvar d = 1; d <= 9; d++) begin : g_trial
        localparam sitda_pkg::scaled_row_t ROW = sitda_pkg::scaled_row(d);
        assign diff[d] = {(sitda_pkg::DIFF_W - sitda_pkg::VALUE_W)'(0), mag_reg}
                       - {1'b0, ROW[decade_reg]};
    end

    // largest multiple that still fits gives the digit
    always_comb begin
        digit     = '0;
        remainder = mag_reg;
        for (int d = 1; d <= 9; d++) begin
            if (!diff[d][sitda_pkg::DIFF_W-1]) begin
                digit     = sitda_pkg::DIGIT_W'(d);
                remainder = diff[d][sitda_pkg::VALUE_W-1:0];
            end
        end
    end

    assign emit_digit = (digit != '0) || started_reg || (decade_reg == '0);

    always_comb begin
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        decade_next  = decade_reg;
        started_next = started_reg;
        valid_next   = valid_reg && !m_tready;
        char_next    = char_reg;
        last_next    = last_reg;

        if (cmd.load) begin
            neg_next     = s_tdata[sitda_pkg::VALUE_W-1];
            mag_next     = s_tdata[sitda_pkg::VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
            decade_next  = sitda_pkg::TOP_DECADE;
            started_next = 1'b0;
        end

        if (cmd.sign && neg_reg) begin
            valid_next = 1'b1;
            char_next  = sitda_pkg::CHAR_MINUS;
            last_next  = 1'b0;
        end

        if (cmd.step) begin
            mag_next    = remainder;
            decade_next = decade_reg - 1'b1;
            if (emit_digit) begin
                started_next = 1'b1;
                valid_next   = 1'b1;
                char_next    = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit);
                last_next    = (decade_reg == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        decade_reg <= decade_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign status.out_stall   = valid_reg && !m_tready;
    assign status.last_decade = (decade_reg == '0);

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

### tb/sv/ascii_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// ascii_scoreboard_pkg
// Predicts the decimal text of each accepted integer and checks the character
// stream coming out of the converter against it, in order.
// ----------------------------------------------------------------------------
package ascii_scoreboard_pkg;

    import sitda_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    class ascii_scoreboard;

        ascii_char_t expected_text[$];
        int unsigned errors;
        int unsigned numbers_seen;

        function new();
            errors       = 0;
            numbers_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_text.size();
        endfunction

        task report(input string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        // Decimal text of a two's complement word: optional minus, then digits
        // MSD first without leading zeros; zero is a single '0'.
        function void note_value(input logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [CHAR_W-1:0]  digits[$];
            ascii_char_t        c;
            logic               neg;
            neg = value[VALUE_W-1];
            // -2^31 wraps back to 0x80000000, which is the right magnitude
            mag = neg ? (~value + 1'b1) : value;
            do begin
                digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (neg) begin
                c.code = CHAR_MINUS;
                c.last = 1'b0;
                expected_text.push_back(c);
            end
            foreach (digits[i]) begin
                c.code = digits[i];
                c.last = (i == digits.size() - 1);
                expected_text.push_back(c);
            end
            numbers_seen++;
        endfunction

        task check_char(input logic [CHAR_W-1:0] code, input logic last);
            ascii_char_t want;
            if (expected_text.size() == 0) begin
                report($sformatf("char 0x%02h last=%0b with nothing expected", code, last));
            end else begin
                want = expected_text.pop_front();
                if (code !== want.code)
                    report($sformatf("number %0d: char 0x%02h, expected 0x%02h",
                                     numbers_seen, code, want.code));
                if (last !== want.last)
                    report($sformatf("number %0d: tlast %0b, expected %0b (char 0x%02h)",
                                     numbers_seen, last, want.last, want.code));
            end
        endtask

    endclass

endpackage

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for signed_int_to_decimal_ascii: directed corner values, then
// random integers of every digit count and sign, with random idling on both
// streams and one long sink hold-off. Every character is checked against a
// predicted text; missing, extra or wrong characters are failures.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sitda_pkg::*;
    import ascii_scoreboard_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 360;
    localparam int HOLD_CYCLES   = 300;     // long sink hold-off, fills the block
    localparam int HOLD_AT_ITEM  = 60;      // random item that starts the hold
    localparam int DRAIN_CYCLES  = 30;      // longer than one full conversion
    localparam int CYCLE_LIMIT   = 200000;  // watchdog limit for the whole run

    // Corner values: zero, single digits, decade boundaries, both extremes,
    // alternating bit patterns so every input bit is seen at 0 and 1.
    localparam logic [VALUE_W-1:0] CORNER_VALUES [19] = '{
        32'd0, 32'd1, 32'(-1), 32'd9, 32'd10, 32'(-10), 32'd99, 32'd100,
        32'h7FFF_FFFF, 32'h8000_0000, 32'(-2147483647), 32'd1000000000,
        32'd999999999, 32'(-999999999), 32'd1234567890, 32'h5555_5555,
        32'hAAAA_AAAA, 32'd7, 32'(-7)
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] char_code
    logic        m_tlast;           // is_last

    logic        start_hold = 1'b0; // raised by the stimulus once
    logic        sink_hold  = 1'b0; // owned by the hold-off process
    bit          src_burst;         // sender runs without gaps while set
    bit          sink_burst;        // sink runs without stalls while set
    int unsigned cycle_count = 0;

    ascii_scoreboard sb = new();

    signed_int_to_decimal_ascii u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Occasionally flips a burst flag, so runs of zero idling show up between
    // stretches of random idle gaps.
    function automatic int unsigned idle_cycles(ref bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // Mostly values with a chosen digit count (so short and long texts are
    // both common), plus raw words and the corner list.
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned pick;
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        int unsigned k;
        logic [VALUE_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom();
        if (pick == 1)
            return CORNER_VALUES[$urandom_range(0, $size(CORNER_VALUES) - 1)];
        ndig = $urandom_range(1, 10);
        p = 1;
        for (k = 1; k < ndig; k++)
            p = p * 10;
        lo = (ndig == 1) ? 0 : p;
        hi = (ndig == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
        v  = $urandom_range(hi, lo);
        if ($urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        return v;
    endfunction

    // One input transaction. The caller sits on a rising edge; tvalid is
    // only lowered when a gap is drawn, so back-to-back items keep it high.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = idle_cycles(src_burst);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_value(value);
    endtask

    // Long hold-off, counted here; the sink only looks at the flag.
    initial begin : hold_off
        @(posedge aclk iff start_hold);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Sink: random stall before each character, longer while held off.
    // Values are sampled at the edge, before any update in that step lands.
    initial begin : char_sink
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = idle_cycles(sink_burst);
            if (stall != 0 || sink_hold) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (sink_hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_char(m_tdata, m_tlast);
        end
    end

    initial begin : stimulus
        int n;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (CORNER_VALUES[i])
            send_value(CORNER_VALUES[i]);

        // random part; the sender keeps offering items through the hold-off
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM)
                start_hold <= 1'b1;
            send_value(random_value());
        end
        s_tvalid <= 1'b0;

        // drain: every expected character in, then a quiet window for strays
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
